@@ sv/mjpid_pkg.sv @@
// Shared constants, register codes and control types for the multi-joint PID block.
`timescale 1ns / 1ps

package mjpid_pkg;

    // Joint table
    localparam int NUM_JOINTS = 8;
    localparam int JOINT_W    = 3;
    localparam int JIDX_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    // Fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 32;
    localparam int GAIN_W    = 32;
    localparam int ERR_W     = POS_W + 1;     // Q17.16 error
    localparam int DIFF_W    = ERR_W + 1;     // error minus last error
    localparam int DERIV_W   = 42;            // diff * 100
    localparam int INTEG_W   = 40;            // Q24.16 integral
    localparam int DT_Q      = ((1 << FRAC_BITS) + 50) / 100;

    // Shared multiplier: 33-bit signed by 25-bit signed, operands split in 24-bit chunks
    localparam int CHUNK_W = 24;
    localparam int OPND_W  = 2 * CHUNK_W;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = CHUNK_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 76;

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 2'd2;

    localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST  = 32'sd3276800;
    localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST = 32'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RST = 32'sd131072;

    // Control of the multiply-accumulate unit
    typedef struct packed {
        logic mul_en;    // capture a product this cycle
        logic acc_clr;   // clear the accumulator
        logic acc_add;   // product captured now is summed next cycle
        logic shift_hi;  // product belongs to the upper chunk
    } mac_ctrl_t;

endpackage

@@ sv/mjpid_mac.sv @@
// Shared multiplier with product register and wide accumulator.
`timescale 1ns / 1ps

module mjpid_mac import mjpid_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mac_ctrl_t                 ctrl,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0]  prod,
    output logic signed [ACC_W-1:0]   acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  addend_ext;
    logic signed [ACC_W-1:0]  addend;
    logic                     add_reg;
    logic                     hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_reg <= 1'b0;
            hi_reg  <= 1'b0;
        end
        else
        begin
            add_reg <= ctrl.mul_en & ctrl.acc_add;
            hi_reg  <= ctrl.shift_hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign addend_ext = ACC_W'(prod_reg);
    assign addend     = hi_reg ? (addend_ext <<< CHUNK_W) : addend_ext;

    // exact modulo 2^ACC_W; the final sum always fits
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (add_reg)
        begin
            acc_reg <= acc_reg + addend;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

@@ sv/mjpid_jstate.sv @@
// Per-joint integral and previous-error store, cleared at reset.
`timescale 1ns / 1ps

module mjpid_jstate import mjpid_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [JIDX_W-1:0]         idx,
    input  logic                      wr_en,
    input  logic signed [INTEG_W-1:0] wr_integ,
    input  logic signed [ERR_W-1:0]   wr_last,
    output logic signed [INTEG_W-1:0] rd_integ,
    output logic signed [ERR_W-1:0]   rd_last
);

    logic signed [INTEG_W-1:0] integ_mem_reg [NUM_JOINTS];
    logic signed [ERR_W-1:0]   last_mem_reg  [NUM_JOINTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                integ_mem_reg[i] <= '0;
                last_mem_reg[i]  <= '0;
            end
        end
        else if (wr_en)
        begin
            integ_mem_reg[idx] <= wr_integ;
            last_mem_reg[idx]  <= wr_last;
        end
    end

    assign rd_integ = integ_mem_reg[idx];
    assign rd_last  = last_mem_reg[idx];

endmodule

@@ sv/multi_joint_pid_controller.sv @@
// Top level of the multi-joint PID controller: sequencer, datapath and config registers.
// An accepted input beat runs through load, derivative, integral, gain products, drain and saturate,
// and a new sample is taken only once idle again; the shared 33x25 multiplier makes six passes
//   (three gain products, each split into two 24-bit operand chunks) plus the dt product.
// Reset (rst_n, async, active low): gains return to 50.0 / 0.0 / 2.0, every joint's
//   integral and previous error clear to zero, sequencer idles, no output beat pending.
`timescale 1ns / 1ps

module multi_joint_pid_controller import mjpid_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    // input beat: one joint sample
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [JOINT_W-1:0]         joint,
    input  logic signed [POS_W-1:0]    target_pos,
    input  logic signed [POS_W-1:0]    measured_pos,

    // output beat: one drive command
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [JOINT_W-1:0]         joint_out,
    output logic signed [POS_W-1:0]    command,

    // gain register writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [GAIN_W-1:0]          cfg_data
);

    // ------------------------------------------------------------------
    // Sequencer codes
    // ------------------------------------------------------------------
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for an input beat
    localparam logic [2:0] ST_LOAD  = 3'd1;  // form error, fetch joint state
    localparam logic [2:0] ST_DERIV = 3'd2;  // derivative; error*dt into multiplier
    localparam logic [2:0] ST_INTEG = 3'd3;  // update integral; first gain product
    localparam logic [2:0] ST_MUL   = 3'd4;  // remaining gain products
    localparam logic [2:0] ST_DRAIN = 3'd5;  // last product lands in accumulator
    localparam logic [2:0] ST_SAT   = 3'd6;  // shift, saturate, load output register

    // Multiplier pass order: (gain, operand chunk)
    localparam logic [2:0] STEP_P_LO = 3'd0;
    localparam logic [2:0] STEP_P_HI = 3'd1;
    localparam logic [2:0] STEP_D_LO = 3'd2;
    localparam logic [2:0] STEP_D_HI = 3'd3;
    localparam logic [2:0] STEP_I_LO = 3'd4;
    localparam logic [2:0] STEP_I_HI = 3'd5;

    localparam int SAT_TOP_W = ACC_W - FRAC_BITS - POS_W + 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]                state_reg, state_next;
    logic [2:0]                step_reg,  step_next;
    logic                      out_valid_reg;
    logic                      jok_reg;

    logic signed [GAIN_W-1:0]  gain_prop_reg;
    logic signed [GAIN_W-1:0]  gain_integ_reg;
    logic signed [GAIN_W-1:0]  gain_deriv_reg;

    logic [JOINT_W-1:0]        joint_reg;
    logic signed [POS_W-1:0]   target_reg;
    logic signed [POS_W-1:0]   measured_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [INTEG_W-1:0] iold_reg;
    logic signed [ERR_W-1:0]   last_reg;
    logic signed [DERIV_W-1:0] deriv_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic [JOINT_W-1:0]        joint_out_reg;
    logic signed [POS_W-1:0]   command_reg;

    // ------------------------------------------------------------------
    // Datapath wires
    // ------------------------------------------------------------------
    logic                        in_beat;
    logic                        out_free;
    logic                        joint_ok;
    logic signed [ERR_W-1:0]     err_calc;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [DERIV_W-1:0]   diff_ext;
    logic signed [DERIV_W-1:0]   deriv_calc;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    prod_shift;
    logic signed [INTEG_W+2:0]   integ_sum;
    logic signed [INTEG_W-1:0]   integ_sat;
    logic signed [INTEG_W-1:0]   st_integ;
    logic signed [ERR_W-1:0]     st_last;
    logic                        st_wr_en;
    logic [2:0]                  mul_step;
    logic signed [OPND_W-1:0]    opnd;
    logic signed [GAIN_W-1:0]    gain_sel;
    logic signed [MUL_A_W-1:0]   op_a;
    logic signed [MUL_B_W-1:0]   op_b;
    logic signed [ACC_W-1:0]     acc;
    logic [SAT_TOP_W-1:0]        sat_top;
    logic signed [POS_W-1:0]     cmd_sat;
    mac_ctrl_t                   mac_ctrl;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_beat   = in_valid & in_ready;
    assign out_free  = ~out_valid_reg | out_ready;
    assign cfg_ready = 1'b1;

    // joints past the table give a zero command and leave state alone
    assign joint_ok = ({1'b0, joint_reg} < (JOINT_W + 1)'(NUM_JOINTS));

    // error = target - measured, exact in 33 bits
    assign err_calc = {target_reg[POS_W-1], target_reg} - {measured_reg[POS_W-1], measured_reg};

    // derivative = (error - last error) * 100, built as 64 + 32 + 4
    assign diff       = {err_reg[ERR_W-1], err_reg} - {last_reg[ERR_W-1], last_reg};
    assign diff_ext   = DERIV_W'(diff);
    assign deriv_calc = (diff_ext <<< 6) + (diff_ext <<< 5) + (diff_ext <<< 2);

    // integral += floor(error*dt / 2^FRAC_BITS), saturated to 40 bits
    assign prod_shift = prod >>> FRAC_BITS;
    assign integ_sum  = (INTEG_W + 3)'(iold_reg) + (INTEG_W + 3)'(prod_shift);

    always_comb
    begin
        if ((&integ_sum[INTEG_W+2:INTEG_W-1]) || !(|integ_sum[INTEG_W+2:INTEG_W-1]))
        begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
        else if (integ_sum[INTEG_W+2])
        begin
            integ_sat = {1'b1, {(INTEG_W-1){1'b0}}};
        end
        else
        begin
            integ_sat = {1'b0, {(INTEG_W-1){1'b1}}};
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier operand selection
    // ------------------------------------------------------------------
    assign mul_step = (state_reg == ST_MUL) ? step_reg : STEP_P_LO;

    always_comb
    begin
        case (mul_step)
            STEP_P_LO, STEP_P_HI:
            begin
                opnd     = OPND_W'(err_reg);
                gain_sel = gain_prop_reg;
            end
            STEP_D_LO, STEP_D_HI:
            begin
                opnd     = OPND_W'(deriv_reg);
                gain_sel = gain_deriv_reg;
            end
            STEP_I_LO, STEP_I_HI:
            begin
                opnd     = OPND_W'(integ_reg);
                gain_sel = gain_integ_reg;
            end
            default:
            begin
                opnd     = '0;
                gain_sel = '0;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_DERIV)
        begin
            // error * dt for the integral update
            op_a = MUL_A_W'(err_reg);
            op_b = MUL_B_W'(DT_Q);
        end
        else
        begin
            op_a = MUL_A_W'(gain_sel);
            if (mul_step[0])
            begin
                op_b = {opnd[OPND_W-1], opnd[OPND_W-1:CHUNK_W]};
            end
            else
            begin
                op_b = {1'b0, opnd[CHUNK_W-1:0]};
            end
        end
    end

    always_comb
    begin
        mac_ctrl.mul_en   = (state_reg == ST_DERIV) || (state_reg == ST_INTEG) ||
                            (state_reg == ST_MUL);
        mac_ctrl.acc_clr  = (state_reg == ST_DERIV);
        mac_ctrl.acc_add  = (state_reg == ST_INTEG) || (state_reg == ST_MUL);
        mac_ctrl.shift_hi = mac_ctrl.acc_add & mul_step[0];
    end

    mjpid_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (op_a),
        .op_b  (op_b),
        .prod  (prod),
        .acc   (acc)
    );

    // ------------------------------------------------------------------
    // Per-joint state
    // ------------------------------------------------------------------
    assign st_wr_en = (state_reg == ST_INTEG) && jok_reg;

    mjpid_jstate u_jstate
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .idx      (JIDX_W'(joint_reg)),
        .wr_en    (st_wr_en),
        .wr_integ (integ_sat),
        .wr_last  (err_reg),
        .rd_integ (st_integ),
        .rd_last  (st_last)
    );

    // ------------------------------------------------------------------
    // Final shift by FRAC_BITS and saturation to 32 bits
    // ------------------------------------------------------------------
    assign sat_top = acc[ACC_W-1:FRAC_BITS+POS_W-1];

    always_comb
    begin
        if (!jok_reg)
        begin
            cmd_sat = '0;
        end
        else if ((&sat_top) || !(|sat_top))
        begin
            cmd_sat = acc[FRAC_BITS+POS_W-1:FRAC_BITS];
        end
        else if (acc[ACC_W-1])
        begin
            cmd_sat = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            cmd_sat = {1'b0, {(POS_W-1){1'b1}}};
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = joint_ok ? ST_DERIV : ST_SAT;
            end
            ST_DERIV:
            begin
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                state_next = ST_MUL;
                step_next  = STEP_P_HI;
            end
            ST_MUL:
            begin
                if (step_reg == STEP_I_HI)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= STEP_P_LO;
            out_valid_reg  <= 1'b0;
            jok_reg        <= 1'b0;
            gain_prop_reg  <= GAIN_PROP_RST;
            gain_integ_reg <= GAIN_INTEG_RST;
            gain_deriv_reg <= GAIN_DERIV_RST;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (state_reg == ST_LOAD)
            begin
                jok_reg <= joint_ok;
            end

            if ((state_reg == ST_SAT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                    REG_GAIN_INTEG: gain_integ_reg <= cfg_data;
                    REG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            joint_reg    <= joint;
            target_reg   <= target_pos;
            measured_reg <= measured_pos;
        end
        if (state_reg == ST_LOAD)
        begin
            err_reg  <= err_calc;
            iold_reg <= st_integ;
            last_reg <= st_last;
        end
        if (state_reg == ST_DERIV)
        begin
            deriv_reg <= deriv_calc;
        end
        if (state_reg == ST_INTEG)
        begin
            integ_reg <= integ_sat;
        end
        if ((state_reg == ST_SAT) && out_free)
        begin
            joint_out_reg <= joint_reg;
            command_reg   <= cmd_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign joint_out = joint_out_reg;
    assign command   = command_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_LOAD))
        else $error("accepted beat did not start the sequencer");

    a_sat_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SAT) && out_free) |=> out_valid_reg)
        else $error("finished result not presented");

    a_bad_joint_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ({1'b0, joint_out_reg} >= (JOINT_W + 1)'(NUM_JOINTS)))
        |-> (command_reg == '0))
        else $error("nonzero command for joint outside table");

    a_no_write_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        st_wr_en |-> $past(state_reg == ST_DERIV))
        else $error("joint state written out of sequence");

endmodule
